>>> hdl/lsc_pkg.sv
// Shared types and constants for the door strike lock controller.
// No dependencies; compiled before every other file of the block.
package lsc_pkg;

    // Timer width of phase, hold and tone counters
    localparam int TIME_BITS = 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [6:0] STARTUP_TICKS = 7'd100;
    localparam logic [31:0] MIN_SETTLE = 32'd400;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_PULSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_PULSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DUTY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_PERIOD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REST          = 3'd7;

    // Phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PULL    = 3'd1;
    localparam logic [2:0] PH_HOLD    = 3'd2;
    localparam logic [2:0] PH_SETTLE  = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    typedef struct packed {
        logic [15:0] lock_timeout;
        logic [7:0]  debounce_ticks;
        logic [11:0] pull_pulse_ticks;
        logic [11:0] release_pulse_ticks;
        logic [7:0]  hold_duty;
        logic [7:0]  release_duty;
        logic [15:0] tone_period;
        logic [11:0] rest_ticks;
    } cfg_t;

    // Core -> debouncer: sample this tick, and/or force stable to the raw sample
    typedef struct packed {
        logic sample;
        logic load;
    } deb_req_t;

    // Debouncer -> core: stable value after this tick's sample, and edge flag
    typedef struct packed {
        logic stable;
        logic changed;
    } deb_stat_t;

    typedef struct packed {
        logic [7:0] motor_left_level;
        logic       motor_right_on;
        logic       buzzer_on;
        logic       lock_open;
    } result_t;

endpackage

>>> hdl/lsc_if.sv
// Valid/ready channel interfaces for the lock controller input and result beats.
// Depends on nothing.
interface lsc_in_if;
    logic valid;
    logic ready;
    logic control_raw;
    logic door_raw;

    modport source (output valid, output control_raw, output door_raw, input ready);
    modport sink (input valid, input control_raw, input door_raw, output ready);
endinterface

interface lsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] motor_left_level;
    logic       motor_right_on;
    logic       buzzer_on;
    logic       lock_open;

    modport source (output valid, output motor_left_level, output motor_right_on,
                    output buzzer_on, output lock_open, input ready);
    modport sink (input valid, input motor_left_level, input motor_right_on,
                  input buzzer_on, input lock_open, output ready);
endinterface

>>> hdl/door_strike_lock_controller.sv
// Top level of the door strike lock controller: input stage, core, result register.
// Depends on lsc_pkg, lsc_if, lsc_cfg_regs, lsc_debounce and lsc_core.
//
//  channel     dir  beat contents                                        handshake
//  item_in     in   control_raw, door_raw (one beat per ms tick)         valid/ready
//  result_out  out  motor_left_level, motor_right_on, buzzer_on,         valid/ready
//                   lock_open (one beat per input beat)
//  cfg_*       in   cfg_index, cfg_data                                  cfg_we only
//
//  Beats pass input, then result register; one beat per cycle unless result_out stalls.
//  The input register feeds a single pass of phase/debounce logic into the result register.
//  Reset (rst_n low, async) puts the lock in release phase with registers at defaults.
//  A stalled result_out holds the result register; the input register then fills and
//  item_in.ready drops until the result is taken.
module door_strike_lock_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    lsc_in_if.sink                        item_in,
    lsc_out_if.source                     result_out,
    input  logic                          cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsc_pkg::*;

    cfg_t      cfg;
    deb_req_t  ctl_req, door_req;
    deb_stat_t ctl_stat, door_stat;
    result_t   result;

    // input stage
    logic s1_valid_reg;
    logic s1_ctl_reg;
    logic s1_door_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_data_reg;

    // one tick of work happens when the input stage holds a beat and
    // the result register is free or being drained this cycle
    logic step;

    assign step          = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !s1_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_in.valid && item_in.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            s1_ctl_reg  <= item_in.control_raw;
            s1_door_reg <= item_in.door_raw;
        end
    end

    lsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsc_debounce u_ctl_deb (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .sample_bit (s1_ctl_reg),
        .thresh     (cfg.debounce_ticks),
        .req        (ctl_req),
        .stat       (ctl_stat)
    );

    lsc_debounce u_door_deb (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .sample_bit (s1_door_reg),
        .thresh     (cfg.debounce_ticks),
        .req        (door_req),
        .stat       (door_stat)
    );

    lsc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .door_bit  (s1_door_reg),
        .cfg       (cfg),
        .ctl_stat  (ctl_stat),
        .door_stat (door_stat),
        .ctl_req   (ctl_req),
        .door_req  (door_req),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.motor_left_level = out_data_reg.motor_left_level;
    assign result_out.motor_right_on   = out_data_reg.motor_right_on;
    assign result_out.buzzer_on        = out_data_reg.buzzer_on;
    assign result_out.lock_open        = out_data_reg.lock_open;

    // release drive and an open lock are mutually exclusive
    a_open_vs_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.lock_open && out_data_reg.motor_right_on))
        else $error("lock_open and release drive both set");

    // a processed beat always lands in the result register
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result register empty after a processed beat");

    // a held input beat is not dropped while the result side stalls
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !step) |=> s1_valid_reg)
        else $error("input beat lost during stall");

    // buzzer only sounds while the lock is open
    a_buzz_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.buzzer_on) |-> out_data_reg.lock_open)
        else $error("buzzer on with lock closed");

endmodule

>>> hdl/lsc_cfg_regs.sv
// Configuration register file of the lock controller.
// Depends on lsc_pkg.
module lsc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output lsc_pkg::cfg_t                 cfg
);
    import lsc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_timeout        <= 16'd30000;
            cfg_reg.debounce_ticks      <= 8'd50;
            cfg_reg.pull_pulse_ticks    <= 12'd250;
            cfg_reg.release_pulse_ticks <= 12'd250;
            cfg_reg.hold_duty           <= 8'd96;
            cfg_reg.release_duty        <= 8'd128;
            cfg_reg.tone_period         <= 16'd1000;
            cfg_reg.rest_ticks          <= 12'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCK_TIMEOUT:  cfg_reg.lock_timeout        <= cfg_data;
                REG_DEBOUNCE:      cfg_reg.debounce_ticks      <= cfg_data[7:0];
                REG_PULL_PULSE:    cfg_reg.pull_pulse_ticks    <= cfg_data[11:0];
                REG_RELEASE_PULSE: cfg_reg.release_pulse_ticks <= cfg_data[11:0];
                REG_HOLD_DUTY:     cfg_reg.hold_duty           <= cfg_data[7:0];
                REG_RELEASE_DUTY:  cfg_reg.release_duty        <= cfg_data[7:0];
                REG_TONE_PERIOD:   cfg_reg.tone_period         <= cfg_data;
                REG_REST:          cfg_reg.rest_ticks          <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/lsc_debounce.sv
// One-bit input debouncer: last sample, saturating quiet count, stable value.
// Depends on lsc_pkg.
module lsc_debounce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               sample_bit,
    input  logic [7:0]         thresh,
    input  lsc_pkg::deb_req_t  req,
    output lsc_pkg::deb_stat_t stat
);
    import lsc_pkg::*;

    logic       last_reg, last_next;
    logic [7:0] quiet_reg, quiet_next;
    logic       stable_reg, stable_next;
    logic       deb_stable;
    logic       deb_changed;

    always_comb
    begin
        last_next   = last_reg;
        quiet_next  = quiet_reg;
        deb_stable  = stable_reg;
        deb_changed = 1'b0;
        if (req.sample)
        begin
            if (sample_bit != last_reg)
            begin
                last_next  = sample_bit;
                quiet_next = 8'd0;
            end
            else if (quiet_reg != 8'hFF)
            begin
                quiet_next = quiet_reg + 8'd1;
            end
            if (sample_bit != stable_reg && quiet_next > thresh)
            begin
                deb_stable  = sample_bit;
                deb_changed = 1'b1;
            end
        end
        // forced load wins over the debounced value
        stable_next = req.load ? sample_bit : deb_stable;
    end

    assign stat.stable  = deb_stable;
    assign stat.changed = deb_changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= 1'b0;
            quiet_reg  <= 8'd0;
            stable_reg <= 1'b0;
        end
        else if (step)
        begin
            last_reg   <= last_next;
            quiet_reg  <= quiet_next;
            stable_reg <= stable_next;
        end
    end

endmodule

>>> hdl/lsc_core.sv
// Phase sequencer of the lock controller: phase, timers, startup guard, outputs.
// Depends on lsc_pkg; drives the two lsc_debounce instances through deb_req_t.
module lsc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               door_bit,
    input  lsc_pkg::cfg_t      cfg,
    input  lsc_pkg::deb_stat_t ctl_stat,
    input  lsc_pkg::deb_stat_t door_stat,
    output lsc_pkg::deb_req_t  ctl_req,
    output lsc_pkg::deb_req_t  door_req,
    output lsc_pkg::result_t   result
);
    import lsc_pkg::*;

    logic [2:0]           phase_reg, phase_next;
    logic [TIME_BITS-1:0] pt_reg, pt_next;
    logic [TIME_BITS-1:0] oe_reg, oe_next;
    logic [TIME_BITS-1:0] tt_reg, tt_next;
    logic                 dao_reg, dao_next;
    logic [6:0]           startup_reg, startup_next;

    logic                 active;
    logic [2:0]           ph1;
    logic [TIME_BITS-1:0] pt1, oe1, tt1;
    logic                 pull_end1;
    logic                 sample_en;

    // Settle ends after max(400 - hold time, 0) + rest ticks, or at timer saturation
    function automatic logic settle_done(input logic [TIME_BITS-1:0] pt,
                                         input logic [TIME_BITS-1:0] oe,
                                         input logic [11:0] rest);
        logic [31:0] wait_len;
        begin
            wait_len = (32'(oe) < MIN_SETTLE) ? (MIN_SETTLE - 32'(oe)) : 32'd0;
            settle_done = (32'(pt) >= wait_len + 32'(rest)) || (pt == TIME_MAX);
        end
    endfunction

    assign active = (startup_reg >= STARTUP_TICKS);

    // Phase completion at the start of the tick
    always_comb
    begin
        ph1       = phase_reg;
        pt1       = pt_reg;
        oe1       = oe_reg;
        tt1       = tt_reg;
        pull_end1 = 1'b0;
        if (ph1 > PH_RELEASE)
        begin
            ph1 = PH_IDLE;
        end
        if (ph1 == PH_PULL && 32'(pt1) >= 32'(cfg.pull_pulse_ticks))
        begin
            ph1       = PH_HOLD;
            pt1       = '0;
            oe1       = '0;
            tt1       = '0;
            pull_end1 = 1'b1;
        end
        if (ph1 == PH_SETTLE && settle_done(pt1, oe1, cfg.rest_ticks))
        begin
            ph1 = PH_RELEASE;
            pt1 = '0;
        end
        if (ph1 == PH_RELEASE && 32'(pt1) >= 32'(cfg.release_pulse_ticks))
        begin
            ph1 = PH_IDLE;
            pt1 = '0;
        end
        sample_en = active && (ph1 == PH_IDLE || ph1 == PH_HOLD);
    end

    // Request, hold exit, outputs and timer updates
    always_comb
    begin
        logic [2:0]           ph;
        logic [TIME_BITS-1:0] pt, oe, tt;
        logic                 dao;
        logic                 door_load;
        logic                 door_st;
        begin
            ph        = ph1;
            pt        = pt1;
            oe        = oe1;
            tt        = tt1;
            dao       = dao_reg;
            door_load = pull_end1;
            result    = '0;

            if (sample_en && ph == PH_IDLE && ctl_stat.changed && ctl_stat.stable)
            begin
                dao = door_stat.stable;
                ph  = PH_PULL;
                pt  = '0;
                // zero-length pull goes straight to hold
                if (cfg.pull_pulse_ticks == 12'd0)
                begin
                    ph        = PH_HOLD;
                    oe        = '0;
                    tt        = '0;
                    door_load = 1'b1;
                end
            end

            door_st = door_load ? door_bit : door_stat.stable;

            if (ph == PH_HOLD && (door_st != dao || 32'(oe) >= 32'(cfg.lock_timeout)))
            begin
                ph = PH_SETTLE;
                pt = '0;
                if (settle_done(pt, oe, cfg.rest_ticks))
                begin
                    ph = PH_RELEASE;
                    if (cfg.release_pulse_ticks == 12'd0)
                    begin
                        ph = PH_IDLE;
                    end
                end
            end

            case (ph)
                PH_PULL:
                begin
                    result.motor_left_level = 8'hFF;
                    result.lock_open        = 1'b1;
                end
                PH_HOLD:
                begin
                    result.motor_left_level = cfg.hold_duty;
                    result.lock_open        = 1'b1;
                    result.buzzer_on        = (32'(tt) < 32'(cfg.tone_period >> 1));
                end
                PH_SETTLE:
                begin
                    result.lock_open = 1'b1;
                end
                PH_RELEASE:
                begin
                    result.motor_left_level = 8'hFF - cfg.release_duty;
                    result.motor_right_on   = 1'b1;
                end
                default: ;
            endcase

            if (ph == PH_HOLD)
            begin
                if (oe != TIME_MAX)
                begin
                    oe = oe + 1'b1;
                end
                tt = tt + 1'b1;
                if (32'(tt) >= 32'(cfg.tone_period))
                begin
                    tt = '0;
                end
            end
            else if (ph != PH_IDLE && pt != TIME_MAX)
            begin
                pt = pt + 1'b1;
            end

            phase_next   = ph;
            pt_next      = pt;
            oe_next      = oe;
            tt_next      = tt;
            dao_next     = dao;
            startup_next = active ? startup_reg : startup_reg + 7'd1;
            door_req.sample = sample_en;
            door_req.load   = door_load;
        end
    end

    assign ctl_req.sample = sample_en;
    assign ctl_req.load   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RELEASE;
            pt_reg      <= '0;
            oe_reg      <= '0;
            tt_reg      <= '0;
            dao_reg     <= 1'b0;
            startup_reg <= 7'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pt_reg      <= pt_next;
            oe_reg      <= oe_next;
            tt_reg      <= tt_next;
            dao_reg     <= dao_next;
            startup_reg <= startup_next;
        end
    end

endmodule
